// File: hw/rtl/number_literal_to_binary_unit_macros.svh
// Assertion macros shared by the RTL.
`ifndef NUMBER_LITERAL_TO_BINARY_UNIT_MACROS_SVH
`define NUMBER_LITERAL_TO_BINARY_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NLB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define NLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/nlb_pkg.sv
package nlb_pkg;

   localparam int VALUE_BITS = 64;

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   localparam logic [1:0] PREFIX_LEN = 2'd2;

   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_ONE        = 8'h31;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [3:0] HEX_TEN         = 4'hA;

   typedef struct packed {
      logic [7:0] ch;
      logic [1:0] radix_mode;
      logic       first;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
   } rsp_payload_type;

   function automatic logic is_dec_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // Map a character to its hex digit value; non-digits give zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         d = c - CHAR_ZERO;
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         d = c - CHAR_LOWER_A + {4'd0, HEX_TEN};
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         d = c - CHAR_UPPER_A + {4'd0, HEX_TEN};
      end
      return d[3:0];
   endfunction

endpackage

// File: hw/rtl/nlb_stream_if.sv
interface nlb_stream_if #(
   parameter type payload_type = logic
) (
   input logic clock
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      input  clock,
      output valid,
      input  ready,
      output payload
   );

   modport sink (
      input  clock,
      input  valid,
      output ready,
      input  payload
   );

endinterface

// File: hw/rtl/number_literal_to_binary_unit.sv
// Converts a numeric literal, fed one character per transaction with its radix
// (binary, decimal, hexadecimal) and first/last marks, into an unsigned value of
// VALUE_WIDTH bits that wraps on overflow and is zero-extended to 64 bits on rsp.
// Binary and hex tokens skip their first two characters as the prefix. A new
// character is taken every cycle unless the request side stalls: each one
// passes from the request register through one shift-or-multiply-by-ten add
// into the accumulator, and the last character of a token loads the result
// register as it leaves the request register. The request side stalls only
// when a last character meets a result that rsp has not yet taken.
`include "number_literal_to_binary_unit_macros.svh"

module number_literal_to_binary_unit
   import nlb_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input logic  clock,
   input logic  reset,
   nlb_stream_if.sink   req,
   nlb_stream_if.source rsp
);

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   req_payload_type        s1_ff;
   logic                   s1_advance;
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic [VALUE_WIDTH-1:0] acc_in;
   logic [1:0]             prefix_ff;
   logic [1:0]             prefix_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rsp_payload_type        out_ff;

   logic [VALUE_WIDTH-1:0] base_acc;
   logic [1:0]             base_prefix;
   logic                   in_prefix;
   logic [VALUE_WIDTH-1:0] dec_digit;
   logic [VALUE_WIDTH-1:0] hex_value;

   assign s1_advance  = !s1_ff.last || !out_valid_ff || rsp.ready;
   assign req.ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req.valid || (s1_valid_ff && !s1_advance);

   always_comb begin
      base_acc    = s1_ff.first ? '0 : acc_ff;
      base_prefix = s1_ff.first ? 2'd0 : prefix_ff;
      in_prefix   = base_prefix < PREFIX_LEN;
      dec_digit   = VALUE_WIDTH'(s1_ff.ch - CHAR_ZERO);
      hex_value   = VALUE_WIDTH'(hex_digit(s1_ff.ch));
      acc_in      = base_acc;
      prefix_in   = base_prefix;
      case (s1_ff.radix_mode)
         RADIX_BIN: begin
            if (in_prefix) begin
               prefix_in = base_prefix + 2'd1;
            end else if (s1_ff.ch == CHAR_ONE) begin
               acc_in = {base_acc[VALUE_WIDTH-2:0], 1'b1};
            end else if (s1_ff.ch == CHAR_ZERO) begin
               acc_in = {base_acc[VALUE_WIDTH-2:0], 1'b0};
            end
         end
         RADIX_DEC: begin
            if (is_dec_digit(s1_ff.ch)) begin
               acc_in = (base_acc << 3) + (base_acc << 1) + dec_digit;
            end
         end
         RADIX_HEX: begin
            if (in_prefix) begin
               prefix_in = base_prefix + 2'd1;
            end else if (s1_ff.ch != CHAR_UNDERSCORE) begin
               acc_in = (base_acc << 4) + hex_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      if (s1_valid_ff && s1_advance && s1_ff.last) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prefix_ff    <= 2'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_valid_ff && s1_advance) begin
            acc_ff    <= acc_in;
            prefix_ff <= prefix_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_ff <= req.payload;
      end
      if (s1_valid_ff && s1_advance && s1_ff.last) begin
         out_ff.value <= VALUE_BITS'(acc_in);
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   `NLB_ASSERT_NOW(a_prefix_bound, clock, reset, 1'b1, prefix_ff <= PREFIX_LEN)
   `NLB_ASSERT_NEXT(a_last_loads_result, clock, reset,
      s1_valid_ff && s1_advance && s1_ff.last, out_valid_ff)
   `NLB_ASSERT_NEXT(a_stall_holds_item, clock, reset,
      s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_ff) && $stable(acc_ff))
   `NLB_ASSERT_NEXT(a_no_spurious_result, clock, reset,
      !out_valid_ff && !(s1_valid_ff && s1_ff.last), !out_valid_ff)
   `NLB_ASSERT_NOW(a_upper_bits_zero, clock, reset, out_valid_ff,
      (out_ff.value >> VALUE_WIDTH) == '0)

endmodule
